// File: rtl/pol_pkg.sv
package pol_pkg;

    // Token kinds as carried in token_kind
    typedef enum logic [4:0] {
        K_LPAREN  = 5'd0,
        K_RPAREN  = 5'd1,
        K_LBRACE  = 5'd2,
        K_RBRACE  = 5'd3,
        K_COMMA   = 5'd4,
        K_SEMI    = 5'd5,
        K_DOT     = 5'd6,
        K_PLUS    = 5'd7,
        K_MINUS   = 5'd8,
        K_STAR    = 5'd9,
        K_SLASH   = 5'd10,
        K_EQ      = 5'd11,
        K_EQ_EQ   = 5'd12,
        K_BANG    = 5'd13,
        K_BANG_EQ = 5'd14,
        K_LT      = 5'd15,
        K_LT_EQ   = 5'd16,
        K_GT      = 5'd17,
        K_GT_EQ   = 5'd18,
        K_EOF     = 5'd19,
        K_ERROR   = 5'd20
    } kind_t;

    // Scanner mode, one-hot
    typedef enum logic [6:0] {
        M_NORMAL  = 7'b000_0001,
        M_EQ      = 7'b000_0010,
        M_BANG    = 7'b000_0100,
        M_LT      = 7'b000_1000,
        M_GT      = 7'b001_0000,
        M_SLASH   = 7'b010_0000,
        M_COMMENT = 7'b100_0000
    } mode_t;

    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_BANG   = 8'h21;
    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_RPAREN = 8'h29;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_PLUS   = 8'h2B;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_DOT    = 8'h2E;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_SEMI   = 8'h3B;
    localparam logic [7:0] CH_LT     = 8'h3C;
    localparam logic [7:0] CH_EQUAL  = 8'h3D;
    localparam logic [7:0] CH_GT     = 8'h3E;
    localparam logic [7:0] CH_LBRACE = 8'h7B;
    localparam logic [7:0] CH_RBRACE = 8'h7D;

    localparam logic [15:0] LINE_FIRST = 16'd1;
    localparam logic [15:0] LINE_LAST  = 16'hFFFF;

    typedef struct packed {
        logic [7:0] char_code;
        logic       end_of_source;
    } src_item_t;

    typedef struct packed {
        kind_t       token_kind;
        logic [15:0] line_number;
        logic [15:0] lexeme_start;
        logic [1:0]  lexeme_length;
        logic        last_of_run;
    } tok_item_t;

    // Tokens produced by one source byte, in order
    typedef struct packed {
        logic [1:0] count;
        tok_item_t  first;
        tok_item_t  second;
    } push_t;

    typedef struct packed {
        logic       room;
        logic [2:0] level;
    } queue_status_t;

endpackage

// File: rtl/pol_scan.sv
module pol_scan
    import pol_pkg::*;
#(
    parameter int POSITION_BITS = 16
)
(
    input  src_item_t                item,
    input  mode_t                    mode,
    input  logic [15:0]              line,
    input  logic [POSITION_BITS-1:0] pos,
    input  logic [POSITION_BITS-1:0] pend,
    output mode_t                    mode_next,
    output logic [15:0]              line_next,
    output logic [POSITION_BITS-1:0] pos_next,
    output logic [POSITION_BITS-1:0] pend_next,
    output push_t                    push
);

    logic [POSITION_BITS+15:0] pos_ext;
    logic [POSITION_BITS+15:0] pend_ext;
    logic                      nrm_hit;
    logic                      nrm_nl;
    kind_t                     nrm_kind;
    mode_t                     nrm_mode;
    logic                      take_nrm;
    logic                      flush;
    logic                      dbl;
    logic                      eof;
    logic                      p_sel;
    logic                      q_sel;
    kind_t                     single_kind;
    kind_t                     double_kind;
    tok_item_t                 p_tok;
    tok_item_t                 q_tok;

    assign pos_ext  = {16'b0, pos};
    assign pend_ext = {16'b0, pend};

    // Classify the byte as scanned from normal mode
    always_comb
    begin
        nrm_hit  = 1'b0;
        nrm_nl   = 1'b0;
        nrm_kind = K_ERROR;
        nrm_mode = M_NORMAL;
        case (item.char_code)
            CH_SPACE, CH_TAB, CH_CR: ;
            CH_LF:     nrm_nl = 1'b1;
            CH_LPAREN: begin nrm_hit = 1'b1; nrm_kind = K_LPAREN; end
            CH_RPAREN: begin nrm_hit = 1'b1; nrm_kind = K_RPAREN; end
            CH_LBRACE: begin nrm_hit = 1'b1; nrm_kind = K_LBRACE; end
            CH_RBRACE: begin nrm_hit = 1'b1; nrm_kind = K_RBRACE; end
            CH_COMMA:  begin nrm_hit = 1'b1; nrm_kind = K_COMMA;  end
            CH_SEMI:   begin nrm_hit = 1'b1; nrm_kind = K_SEMI;   end
            CH_DOT:    begin nrm_hit = 1'b1; nrm_kind = K_DOT;    end
            CH_PLUS:   begin nrm_hit = 1'b1; nrm_kind = K_PLUS;   end
            CH_MINUS:  begin nrm_hit = 1'b1; nrm_kind = K_MINUS;  end
            CH_STAR:   begin nrm_hit = 1'b1; nrm_kind = K_STAR;   end
            CH_EQUAL:  nrm_mode = M_EQ;
            CH_BANG:   nrm_mode = M_BANG;
            CH_LT:     nrm_mode = M_LT;
            CH_GT:     nrm_mode = M_GT;
            CH_SLASH:  nrm_mode = M_SLASH;
            default:   nrm_hit = 1'b1;
        endcase
    end

    // Single and two-character kinds of the pending operator
    always_comb
    begin
        case (mode)
            M_EQ:    begin single_kind = K_EQ;   double_kind = K_EQ_EQ;   end
            M_BANG:  begin single_kind = K_BANG; double_kind = K_BANG_EQ; end
            M_LT:    begin single_kind = K_LT;   double_kind = K_LT_EQ;   end
            M_GT:    begin single_kind = K_GT;   double_kind = K_GT_EQ;   end
            default: begin single_kind = K_SLASH; double_kind = K_SLASH;  end
        endcase
    end

    always_comb
    begin
        take_nrm = 1'b0;
        flush    = 1'b0;
        dbl      = 1'b0;
        eof      = 1'b0;
        mode_next = mode;
        if (item.end_of_source)
        begin
            eof   = 1'b1;
            flush = (mode == M_EQ) || (mode == M_BANG) || (mode == M_LT)
                    || (mode == M_GT) || (mode == M_SLASH);
            mode_next = M_NORMAL;
        end
        else
        begin
            case (mode)
                M_EQ, M_BANG, M_LT, M_GT:
                begin
                    if (item.char_code == CH_EQUAL)
                    begin
                        dbl       = 1'b1;
                        mode_next = M_NORMAL;
                    end
                    else
                    begin
                        flush    = 1'b1;
                        take_nrm = 1'b1;
                    end
                end
                M_SLASH:
                begin
                    if (item.char_code == CH_SLASH)
                    begin
                        mode_next = M_COMMENT;
                    end
                    else
                    begin
                        flush    = 1'b1;
                        take_nrm = 1'b1;
                    end
                end
                M_COMMENT:
                begin
                    take_nrm = (item.char_code == CH_LF);
                end
                default:
                begin
                    take_nrm = 1'b1;
                end
            endcase
            if (take_nrm)
            begin
                mode_next = nrm_mode;
            end
        end
    end

    always_comb
    begin
        if (item.end_of_source)
        begin
            line_next = LINE_FIRST;
            pos_next  = '0;
            pend_next = '0;
        end
        else
        begin
            line_next = (take_nrm && nrm_nl && line != LINE_LAST) ? line + 16'd1 : line;
            pos_next  = (pos != {POSITION_BITS{1'b1}}) ? pos + 1'b1 : pos;
            pend_next = (take_nrm && nrm_mode != M_NORMAL) ? pos : pend;
        end
    end

    // Pending-character token first, then the byte's own token or end-of-file
    always_comb
    begin
        p_sel = flush || dbl;
        q_sel = eof || (take_nrm && nrm_hit);

        p_tok.token_kind    = dbl ? double_kind : single_kind;
        p_tok.line_number   = line;
        p_tok.lexeme_start  = pend_ext[15:0];
        p_tok.lexeme_length = dbl ? 2'd2 : 2'd1;
        p_tok.last_of_run   = !q_sel;

        q_tok.token_kind    = eof ? K_EOF : nrm_kind;
        q_tok.line_number   = line;
        q_tok.lexeme_start  = pos_ext[15:0];
        q_tok.lexeme_length = eof ? 2'd0 : 2'd1;
        q_tok.last_of_run   = 1'b1;

        push.count  = {1'b0, p_sel} + {1'b0, q_sel};
        push.first  = p_sel ? p_tok : q_tok;
        push.second = q_tok;
    end

endmodule

// File: rtl/pol_queue.sv
module pol_queue
    import pol_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  push_t         push,
    output tok_item_t     tok_item,
    output logic          tok_valid,
    input  logic          tok_stall,
    output queue_status_t status
);

    localparam int DEPTH = 4;

    tok_item_t  entry_reg [DEPTH];
    logic [1:0] wptr_reg;
    logic [1:0] wptr_next;
    logic [1:0] rptr_reg;
    logic [1:0] rptr_next;
    logic [2:0] level_reg;
    logic [2:0] level_next;
    logic [1:0] wptr_plus;
    logic       pop;

    assign tok_valid    = (level_reg != 3'd0);
    assign tok_item     = entry_reg[rptr_reg];
    assign pop          = tok_valid && !tok_stall;
    assign wptr_plus    = wptr_reg + 2'd1;
    assign status.room  = (level_reg <= 3'(DEPTH - 2));
    assign status.level = level_reg;

    always_comb
    begin
        wptr_next  = wptr_reg + push.count;
        rptr_next  = pop ? rptr_reg + 2'd1 : rptr_reg;
        level_next = level_reg + {1'b0, push.count} - {2'b0, pop};
    end

    // Payload store: no reset
    always_ff @(posedge clk)
    begin
        if (push.count != 2'd0)
        begin
            entry_reg[wptr_reg] <= push.first;
        end
        if (push.count == 2'd2)
        begin
            entry_reg[wptr_plus] <= push.second;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            level_reg <= '0;
        end
        else
        begin
            wptr_reg  <= wptr_next;
            rptr_reg  <= rptr_next;
            level_reg <= level_next;
        end
    end

endmodule

// File: rtl/punctuation_operator_lexer_top.sv
// Punctuation and operator lexer.
//
// Source channel (src_valid / src_stall / src_item): one transaction per
// source byte, or an end marker with end_of_source set. Token channel
// (tok_valid / tok_stall / tok_item): one transaction per token; the last
// token caused by a source transaction carries last_of_run.
//
// A byte accepted from the source sits in the input register, where it is
// scanned combinationally; its tokens enter the token queue when the byte
// advances, and the queue offers them from its registered head entry.
// Throughput: one source byte per cycle while the token side keeps up.
// Bytes that form two tokens (a pending operator flushed before the next
// token, or a flush followed by end-of-file) yield two token transactions;
// the four-entry token queue absorbs them and its level sets the stall.
//
// Reset clears the scan mode, sets the line counter to 1 and the byte
// offset to 0, and empties the queue. An end marker restores the mode, line
// and offset so that a new source may follow. When the token receiver stalls, the
// queue fills, the input register holds its byte, and src_stall rises.
module punctuation_operator_lexer_top
    import pol_pkg::*;
#(
    parameter int POSITION_BITS = 16
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      src_valid,
    output logic      src_stall,
    input  src_item_t src_item,
    output logic      tok_valid,
    input  logic      tok_stall,
    output tok_item_t tok_item
);

    logic                      in_vld_reg;
    logic                      in_vld_next;
    src_item_t                 in_item_reg;
    mode_t                     mode_reg;
    mode_t                     mode_next;
    logic [15:0]               line_reg;
    logic [15:0]               line_next;
    logic [POSITION_BITS-1:0]  pos_reg;
    logic [POSITION_BITS-1:0]  pos_next;
    logic [POSITION_BITS-1:0]  pend_reg;
    logic [POSITION_BITS-1:0]  pend_next;
    push_t                     scan_push;
    push_t                     q_push;
    queue_status_t             q_status;
    logic                      advance;
    logic                      accept;

    // Advance the held byte only when the queue can take two tokens
    assign advance   = in_vld_reg && q_status.room;
    assign src_stall = in_vld_reg && !q_status.room;
    assign accept    = src_valid && !src_stall;

    always_comb
    begin
        in_vld_next = in_vld_reg;
        if (accept)
        begin
            in_vld_next = 1'b1;
        end
        else if (advance)
        begin
            in_vld_next = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            in_item_reg <= src_item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg <= 1'b0;
            mode_reg   <= M_NORMAL;
            line_reg   <= LINE_FIRST;
            pos_reg    <= '0;
            pend_reg   <= '0;
        end
        else
        begin
            in_vld_reg <= in_vld_next;
            if (advance)
            begin
                mode_reg <= mode_next;
                line_reg <= line_next;
                pos_reg  <= pos_next;
                pend_reg <= pend_next;
            end
        end
    end

    pol_scan #(
        .POSITION_BITS (POSITION_BITS)
    ) u_scan (
        .item      (in_item_reg),
        .mode      (mode_reg),
        .line      (line_reg),
        .pos       (pos_reg),
        .pend      (pend_reg),
        .mode_next (mode_next),
        .line_next (line_next),
        .pos_next  (pos_next),
        .pend_next (pend_next),
        .push      (scan_push)
    );

    // Drop the push when no byte advances
    always_comb
    begin
        q_push = scan_push;
        if (!advance)
        begin
            q_push.count = 2'd0;
        end
    end

    pol_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .tok_item  (tok_item),
        .tok_valid (tok_valid),
        .tok_stall (tok_stall),
        .status    (q_status)
    );

    // The queue never overflows its four entries
    assert property (@(posedge clk) disable iff (!rst_n)
        q_status.level <= 3'd4)
    else $error("token queue overflow");

    // An end marker restores the reset position and line
    assert property (@(posedge clk) disable iff (!rst_n)
        advance && in_item_reg.end_of_source |=> pos_reg == '0 && line_reg == LINE_FIRST)
    else $error("end marker did not restore scan state");

    // Every end marker yields at least one token, the last flagged
    assert property (@(posedge clk) disable iff (!rst_n)
        advance && in_item_reg.end_of_source |->
            scan_push.count != 2'd0 && (scan_push.count == 2'd1 ?
            scan_push.first.last_of_run : !scan_push.first.last_of_run))
    else $error("end marker token run malformed");

    // The line counter never drops to zero
    assert property (@(posedge clk) disable iff (!rst_n)
        line_reg != 16'd0)
    else $error("line counter reached zero");

endmodule
